// File: sv/rbrs_pkg.sv
// rbrs_pkg: shared widths and defaults for the rank and radix sort block
// no dependencies; imported by rank_and_binary_radix_sort
package rbrs_pkg;

  localparam int ValueW      = 32;
  localparam int RankW       = 6;
  localparam int PassW       = 3;
  localparam int MaxItemsDef = 64;

endpackage

// File: sv/rank_and_binary_radix_sort.sv
// rank_and_binary_radix_sort: loads a set of signed values, ranks them and
// emits them in ascending rank order after lsd binary radix passes on rank
// depends on rbrs_pkg
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  command  | in        | start, busy             | sample_value_i, final_item_i
//  result   | out       | out_strobe_o (1 cycle)  | sorted_value_o, value_rank_o, run_end_o
//
// a non-final beat only stores its value; a final beat with n values stored
// starts ranking (one compare per cycle on the shared comparator), order
// setup, up to 6 passes on the order memory (one write and one read port),
// then one result beat per value, never back to back.
// async active-low reset clears the sequencer and the fill count; the stores
// need no clearing. results cannot be stalled; busy stays high until the last
// beat is issued.
module rank_and_binary_radix_sort #(
  parameter int MaxItems = rbrs_pkg::MaxItemsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [rbrs_pkg::ValueW-1:0] sample_value_i,
  input  logic                               final_item_i,
  output logic                               out_strobe_o,
  output logic signed [rbrs_pkg::ValueW-1:0] sorted_value_o,
  output logic        [rbrs_pkg::RankW-1:0]  value_rank_o,
  output logic                               run_end_o
);
  import rbrs_pkg::*;

  localparam int IdxW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int CntW = $clog2(MaxItems + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RANK_P,
    S_RANK_LD,
    S_RANK_CMP,
    S_INIT,
    S_SPL_RO,
    S_SPL_RR,
    S_SPL_ACT,
    S_CPY_RD,
    S_CPY_WR,
    S_OUT_RO,
    S_OUT_RV,
    S_OUT_EMIT
  } state_e;

  state_e state_q;

  logic signed [ValueW-1:0] value_mem [MaxItems];
  logic        [IdxW-1:0]   rank_mem  [MaxItems];
  logic        [IdxW-1:0]   order_mem [MaxItems];
  logic        [IdxW-1:0]   ones_mem  [MaxItems];

  logic signed [ValueW-1:0] val_rd_q;
  logic        [IdxW-1:0]   rank_rd_q;
  logic        [IdxW-1:0]   order_rd_q;
  logic        [IdxW-1:0]   ones_rd_q;

  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] last_q, p_q, q_q, k_q, r_q, top_q, slot_q;
  logic signed [ValueW-1:0] vp_q;
  logic [PassW-1:0] bits_q, pass_q;
  logic [CntW-1:0] nz_q, no_q;

  logic                     strobe_q, run_end_q;
  logic signed [ValueW-1:0] sorted_q;
  logic [RankW-1:0]         rank_q;

  logic                     val_we, rank_we, order_we, ones_we;
  logic [IdxW-1:0]          val_waddr, val_raddr, rank_raddr;
  logic [IdxW-1:0]          order_waddr, order_wdata;
  logic [IdxW-1:0]          ones_waddr;
  logic [IdxW-1:0]          rsum;
  logic                     lt, split_bit, pass_last, not_full;
  logic [CntW-1:0]          cnt_nxt;
  logic [IdxW-1:0]          shifted_rank;

  function automatic logic [PassW-1:0] bit_len(input logic [IdxW-1:0] x);
    logic [PassW-1:0] len;
    len = '0;
    for (int b = 0; b < IdxW; b++) begin
      if (x[b]) len = PassW'(b + 1);
    end
    return len;
  endfunction

  assign not_full     = (cnt_q < CntW'(MaxItems));
  assign cnt_nxt      = not_full ? cnt_q + CntW'(1) : cnt_q;
  assign lt           = (val_rd_q < vp_q);
  assign rsum         = r_q + IdxW'(lt);
  assign shifted_rank = rank_rd_q >> pass_q;
  assign split_bit    = shifted_rank[0];
  assign pass_last    = ((pass_q + PassW'(1)) == bits_q);

  // memory port control
  always_comb begin
    val_we      = (state_q == S_IDLE) && start && not_full;
    val_waddr   = cnt_q[IdxW-1:0];
    rank_we     = (state_q == S_RANK_CMP) && (q_q == last_q);
    order_we    = 1'b0;
    order_waddr = k_q;
    order_wdata = k_q;
    ones_we     = 1'b0;
    ones_waddr  = no_q[IdxW-1:0];
    val_raddr   = p_q;
    rank_raddr  = order_rd_q;
    unique case (state_q)
      S_RANK_LD:  val_raddr = q_q;
      S_RANK_CMP: val_raddr = q_q + IdxW'(1);
      S_OUT_RV:   val_raddr = order_rd_q;
      S_INIT:     order_we = 1'b1;
      S_SPL_ACT: begin
        if (split_bit) begin
          ones_we = 1'b1;
        end else begin
          order_we    = 1'b1;
          order_waddr = nz_q[IdxW-1:0];
          order_wdata = slot_q;
        end
      end
      S_CPY_WR: begin
        order_we    = 1'b1;
        order_waddr = nz_q[IdxW-1:0] + k_q;
        order_wdata = ones_rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (val_we) value_mem[val_waddr] <= sample_value_i;
    if (rank_we) rank_mem[p_q] <= rsum;
    if (order_we) order_mem[order_waddr] <= order_wdata;
    if (ones_we) ones_mem[ones_waddr] <= slot_q;
    val_rd_q   <= value_mem[val_raddr];
    rank_rd_q  <= rank_mem[rank_raddr];
    order_rd_q <= order_mem[k_q];
    ones_rd_q  <= ones_mem[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      last_q    <= '0;
      p_q       <= '0;
      q_q       <= '0;
      k_q       <= '0;
      r_q       <= '0;
      top_q     <= '0;
      slot_q    <= '0;
      vp_q      <= '0;
      bits_q    <= '0;
      pass_q    <= '0;
      nz_q      <= '0;
      no_q      <= '0;
      strobe_q  <= 1'b0;
      run_end_q <= 1'b0;
      sorted_q  <= '0;
      rank_q    <= '0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            cnt_q <= cnt_nxt;
            if (final_item_i) begin
              last_q  <= IdxW'(cnt_nxt - CntW'(1));
              p_q     <= '0;
              top_q   <= '0;
              state_q <= S_RANK_P;
            end
          end
        end
        S_RANK_P: begin
          q_q     <= '0;
          state_q <= S_RANK_LD;
        end
        S_RANK_LD: begin
          vp_q    <= val_rd_q;
          r_q     <= '0;
          state_q <= S_RANK_CMP;
        end
        S_RANK_CMP: begin
          if (q_q == last_q) begin
            if (rsum > top_q) top_q <= rsum;
            if (p_q == last_q) begin
              k_q     <= '0;
              state_q <= S_INIT;
            end else begin
              p_q     <= p_q + IdxW'(1);
              state_q <= S_RANK_P;
            end
          end else begin
            r_q <= rsum;
            q_q <= q_q + IdxW'(1);
          end
        end
        S_INIT: begin
          if (k_q == last_q) begin
            bits_q  <= bit_len(top_q);
            pass_q  <= '0;
            k_q     <= '0;
            nz_q    <= '0;
            no_q    <= '0;
            state_q <= (bit_len(top_q) == '0) ? S_OUT_RO : S_SPL_RO;
          end else begin
            k_q <= k_q + IdxW'(1);
          end
        end
        S_SPL_RO: state_q <= S_SPL_RR;
        S_SPL_RR: begin
          slot_q  <= order_rd_q;
          state_q <= S_SPL_ACT;
        end
        S_SPL_ACT: begin
          if (split_bit) no_q <= no_q + CntW'(1);
          else nz_q <= nz_q + CntW'(1);
          if (k_q == last_q) begin
            k_q <= '0;
            if (split_bit || (no_q != '0)) begin
              state_q <= S_CPY_RD;
            end else if (pass_last) begin
              state_q <= S_OUT_RO;
            end else begin
              pass_q  <= pass_q + PassW'(1);
              nz_q    <= '0;
              no_q    <= '0;
              state_q <= S_SPL_RO;
            end
          end else begin
            k_q     <= k_q + IdxW'(1);
            state_q <= S_SPL_RO;
          end
        end
        S_CPY_RD: state_q <= S_CPY_WR;
        S_CPY_WR: begin
          if ((CntW'(k_q) + CntW'(1)) == no_q) begin
            k_q <= '0;
            if (pass_last) begin
              state_q <= S_OUT_RO;
            end else begin
              pass_q  <= pass_q + PassW'(1);
              nz_q    <= '0;
              no_q    <= '0;
              state_q <= S_SPL_RO;
            end
          end else begin
            k_q     <= k_q + IdxW'(1);
            state_q <= S_CPY_RD;
          end
        end
        S_OUT_RO: state_q <= S_OUT_RV;
        S_OUT_RV: state_q <= S_OUT_EMIT;
        S_OUT_EMIT: begin
          strobe_q  <= 1'b1;
          sorted_q  <= val_rd_q;
          rank_q    <= RankW'(rank_rd_q);
          run_end_q <= (k_q == last_q);
          if (k_q == last_q) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            k_q     <= k_q + IdxW'(1);
            state_q <= S_OUT_RO;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign out_strobe_o   = strobe_q;
  assign sorted_value_o = sorted_q;
  assign value_rank_o   = rank_q;
  assign run_end_o      = run_end_q;

`ifndef SYNTH
  a_strobe_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |=> !out_strobe_o)
    else $error("result beats back to back");

  a_end_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && run_end_o) |-> !busy)
    else $error("busy after last result beat");

  a_final_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && final_item_i) |=> busy)
    else $error("final beat did not start the sort");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxItems))
    else $error("fill count beyond store depth");
`endif

endmodule
